/* design/assert_macros.svh */
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication or expression, quiet while reset is held.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true on a clock edge outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  `ASSERT_CLK(lbl, !(expr), msg)

`endif

/* design/lstq_pkg.sv */
// Types and constants for the line sensor turn qualifier.
`timescale 1ns / 1ps

package lstq_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int DEB_BITS    = 8;
  localparam int ARM_BITS    = 4;
  localparam int CFG_W       = SAMPLE_BITS;
  localparam int CFG_IDX_W   = 3;
  localparam int NUM_SENSORS = 6;

  localparam int IN_W        = NUM_SENSORS * SAMPLE_BITS + 1;
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W       = 2 + NUM_SENSORS + 3;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  localparam logic [SAMPLE_BITS-1:0] TURN_MIN_RST  = SAMPLE_BITS'(2);
  localparam logic [SAMPLE_BITS-1:0] TURN_MAX_RST  = SAMPLE_BITS'(450);
  localparam logic [SAMPLE_BITS-1:0] TURN_HYST_RST = SAMPLE_BITS'(16);
  localparam logic [SAMPLE_BITS-1:0] TRIM_MIN_RST  = SAMPLE_BITS'(10);
  localparam logic [SAMPLE_BITS-1:0] TRIM_MAX_RST  = SAMPLE_BITS'(100);
  localparam logic [DEB_BITS-1:0]    DEB_RST       = DEB_BITS'(5);
  localparam logic [ARM_BITS-1:0]    ARM_RST       = ARM_BITS'(4);
  localparam logic [DEB_BITS-1:0]    DEB_SAT       = '1;

  typedef enum logic [1:0] {
    DIR_STRAIGHT = 2'd0,
    DIR_LEFT     = 2'd1,
    DIR_RIGHT    = 2'd2
  } dir_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TURN_MIN  = 3'd0,
    REG_TURN_MAX  = 3'd1,
    REG_TURN_HYST = 3'd2,
    REG_TRIM_MIN  = 3'd3,
    REG_TRIM_MAX  = 3'd4,
    REG_DEBOUNCE  = 3'd5,
    REG_ARM_CLEAR = 3'd6
  } cfg_idx_t;

endpackage

/* design/line_sensor_turn_qualifier.sv */
// Line sensor turn qualifier: band tests, debounce, arming, held turn request and trim.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// One item carries six sensor peak-to-peak samples and a turn-done flag and
// gives one result: the held turn direction, the on-line mask and a steering
// trim. An item goes into an input register, is judged by shallow compare and
// count logic, and its result and the updated tracking state are written in
// the same cycle into the result register. The path has two register stages,
// the input register and the result register; out_tvalid rises when the
// item moves from the input to the result register. One item is taken
// every cycle while the result side keeps up; a stall on out_tready holds the
// result register and then the input register, and in_tready drops only when
// both are full. The sustained rate is one item per cycle, set by the single
// compute stage. Turn sensors (left, right) use a band with hysteresis, the
// other four a plain open band. A turn request needs the side debounced for
// debounce_ticks items and the block armed by arm_clear_ticks items with both
// turn sensors off line; left wins a tie. The request holds until turn_done,
// which clears it before the rest of that item is judged. Configuration is
// written through cfg_wr_en, cfg_index, cfg_wdata, by the user only while the
// block is idle (the block does not enforce it); unknown indexes are ignored.
module line_sensor_turn_qualifier (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input item: left_turn_sample, right_turn_sample, center_sample,
  // trim_a_sample, trim_b_sample, trim_c_sample, turn_done, zero pad
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [lstq_pkg::IN_TDATA_W-1:0]    in_tdata,
  // Result item: direction, on_line_mask, steer_trim, zero pad
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [lstq_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                               cfg_wr_en,
  input  logic [lstq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lstq_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int SB = lstq_pkg::SAMPLE_BITS;
  localparam int DB = lstq_pkg::DEB_BITS;
  localparam int AB = lstq_pkg::ARM_BITS;

  // configuration
  logic [SB-1:0] turn_min_r, turn_max_r, turn_hyst_r, trim_min_r, trim_max_r;
  logic [DB-1:0] deb_ticks_r;
  logic [AB-1:0] arm_ticks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_min_r  <= lstq_pkg::TURN_MIN_RST;
      turn_max_r  <= lstq_pkg::TURN_MAX_RST;
      turn_hyst_r <= lstq_pkg::TURN_HYST_RST;
      trim_min_r  <= lstq_pkg::TRIM_MIN_RST;
      trim_max_r  <= lstq_pkg::TRIM_MAX_RST;
      deb_ticks_r <= lstq_pkg::DEB_RST;
      arm_ticks_r <= lstq_pkg::ARM_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        lstq_pkg::REG_TURN_MIN:  turn_min_r  <= cfg_wdata[SB-1:0];
        lstq_pkg::REG_TURN_MAX:  turn_max_r  <= cfg_wdata[SB-1:0];
        lstq_pkg::REG_TURN_HYST: turn_hyst_r <= cfg_wdata[SB-1:0];
        lstq_pkg::REG_TRIM_MIN:  trim_min_r  <= cfg_wdata[SB-1:0];
        lstq_pkg::REG_TRIM_MAX:  trim_max_r  <= cfg_wdata[SB-1:0];
        lstq_pkg::REG_DEBOUNCE:  deb_ticks_r <= cfg_wdata[DB-1:0];
        lstq_pkg::REG_ARM_CLEAR: arm_ticks_r <= cfg_wdata[AB-1:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic                    in_valid_r;
  logic [lstq_pkg::IN_W-1:0] in_data_r;
  logic                    out_valid_r;
  logic                    advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata[lstq_pkg::IN_W-1:0];
    end
  end

  // field split
  logic [SB-1:0] vl, vr, vc, va, vb, vt;
  logic          done;

  assign vl   = in_data_r[0*SB +: SB];
  assign vr   = in_data_r[1*SB +: SB];
  assign vc   = in_data_r[2*SB +: SB];
  assign va   = in_data_r[3*SB +: SB];
  assign vb   = in_data_r[4*SB +: SB];
  assign vt   = in_data_r[5*SB +: SB];
  assign done = in_data_r[6*SB];

  // tracking state
  logic          left_hyst_r, right_hyst_r;
  logic [DB-1:0] left_cnt_r, right_cnt_r;
  logic [AB-1:0] arm_cnt_r;
  logic          armed_r, latched_r;
  lstq_pkg::dir_t held_dir_r;

  logic          left_hyst_nxt, right_hyst_nxt;
  logic [DB-1:0] left_cnt_nxt, right_cnt_nxt;
  logic [AB-1:0] arm_cnt_nxt;
  logic          armed_nxt, latched_nxt;
  lstq_pkg::dir_t held_dir_nxt;

  logic [SB:0]   upper_exit;
  logic          l_enter, l_leave, r_enter, r_leave;
  logic          s_c, s_a, s_b, s_t;
  logic          left_settled, right_settled, any_now;
  logic signed [2:0] trim_nxt;

  // exit threshold above the band, kept one bit wider
  assign upper_exit = {1'b0, turn_max_r} + {1'b0, turn_hyst_r};

  assign l_enter = (vl > turn_min_r) && (vl < turn_max_r);
  assign l_leave = ({1'b0, vl} > upper_exit) ||
                   (({1'b0, vl} + {1'b0, turn_hyst_r}) < {1'b0, turn_min_r});
  assign r_enter = (vr > turn_min_r) && (vr < turn_max_r);
  assign r_leave = ({1'b0, vr} > upper_exit) ||
                   (({1'b0, vr} + {1'b0, turn_hyst_r}) < {1'b0, turn_min_r});

  assign left_hyst_nxt  = left_hyst_r  ? !l_leave : l_enter;
  assign right_hyst_nxt = right_hyst_r ? !r_leave : r_enter;

  assign s_c = (vc > trim_min_r) && (vc < trim_max_r);
  assign s_a = (va > trim_min_r) && (va < trim_max_r);
  assign s_b = (vb > trim_min_r) && (vb < trim_max_r);
  assign s_t = (vt > trim_min_r) && (vt < trim_max_r);

  // saturating debounce counters
  assign left_cnt_nxt  = !left_hyst_nxt  ? '0 :
                         (left_cnt_r  == lstq_pkg::DEB_SAT) ? left_cnt_r  : left_cnt_r  + 1'b1;
  assign right_cnt_nxt = !right_hyst_nxt ? '0 :
                         (right_cnt_r == lstq_pkg::DEB_SAT) ? right_cnt_r : right_cnt_r + 1'b1;

  assign left_settled  = left_cnt_nxt  >= deb_ticks_r;
  assign right_settled = right_cnt_nxt >= deb_ticks_r;
  assign any_now       = left_settled || right_settled;

  always_comb begin
    logic           armed_mid;
    lstq_pkg::dir_t dir_mid;
    // arming: count both-clear items, hold at the target
    arm_cnt_nxt = arm_cnt_r;
    armed_mid   = armed_r;
    if (!left_hyst_nxt && !right_hyst_nxt) begin
      if (arm_cnt_r < arm_ticks_r) arm_cnt_nxt = arm_cnt_r + 1'b1;
      if (arm_cnt_nxt >= arm_ticks_r) armed_mid = 1'b1;
    end else begin
      arm_cnt_nxt = '0;
    end

    // turn-done acts first
    dir_mid      = done ? lstq_pkg::DIR_STRAIGHT : held_dir_r;
    held_dir_nxt = dir_mid;
    latched_nxt  = latched_r;
    armed_nxt    = armed_mid;
    if (dir_mid == lstq_pkg::DIR_STRAIGHT) begin
      if (armed_mid && !latched_r && any_now) begin
        held_dir_nxt = left_settled ? lstq_pkg::DIR_LEFT : lstq_pkg::DIR_RIGHT;
        latched_nxt  = 1'b1;
        armed_nxt    = 1'b0;
      end else if (!any_now) begin
        latched_nxt  = 1'b0;
      end
    end else begin
      latched_nxt = 1'b1;
    end
  end

  // steering trim, trim_c side first
  always_comb begin
    priority if (s_t && s_a && !s_b)  trim_nxt = 3'sd1;
    else if (s_t && s_b && !s_a)      trim_nxt = -3'sd1;
    else if (!s_t && s_a && !s_b)     trim_nxt = 3'sd2;
    else if (!s_t && s_b && !s_a)     trim_nxt = -3'sd2;
    else                              trim_nxt = 3'sd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_hyst_r  <= 1'b0;
      right_hyst_r <= 1'b0;
      left_cnt_r   <= '0;
      right_cnt_r  <= '0;
      arm_cnt_r    <= '0;
      armed_r      <= 1'b0;
      latched_r    <= 1'b0;
      held_dir_r   <= lstq_pkg::DIR_STRAIGHT;
    end else if (advance) begin
      left_hyst_r  <= left_hyst_nxt;
      right_hyst_r <= right_hyst_nxt;
      left_cnt_r   <= left_cnt_nxt;
      right_cnt_r  <= right_cnt_nxt;
      arm_cnt_r    <= arm_cnt_nxt;
      armed_r      <= armed_nxt;
      latched_r    <= latched_nxt;
      held_dir_r   <= held_dir_nxt;
    end
  end

  // result register
  logic [lstq_pkg::OUT_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {trim_nxt, s_t, s_b, s_a, s_c, right_hyst_nxt, left_hyst_nxt,
                     held_dir_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(lstq_pkg::OUT_TDATA_W - lstq_pkg::OUT_W){1'b0}}, out_data_r};

  // checks
  `ASSERT_CLK(a_held_implies_latched, held_dir_r != lstq_pkg::DIR_STRAIGHT |-> latched_r, "turn held without latch")
  `ASSERT_CLK(a_take_disarms, (held_dir_r != lstq_pkg::DIR_STRAIGHT && $past(held_dir_r) == lstq_pkg::DIR_STRAIGHT && $past(rst_n)) |-> !armed_r, "new turn left block armed")
  `ASSERT_NEVER(a_mask_tracks_hyst, out_valid_r && (out_data_r[3:2] != {right_hyst_r, left_hyst_r}), "mask turn bits differ from hysteresis state")

endmodule
